// ----- rtl/efg_pkg.sv -----
// Shared types and codes of the event flag group.
// Depends on nothing; the front end, the back end and the top module import it.
package efg_pkg;

  // Action of one input item.
  typedef enum logic [1:0] {
    ACT_WAIT    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_TIMEOUT = 2'd3
  } action_e;

  // Status codes of one result item.
  localparam logic [2:0] STAT_GRANTED    = 3'd0;
  localparam logic [2:0] STAT_BLOCKED    = 3'd1;
  localparam logic [2:0] STAT_RELEASED   = 3'd2;
  localparam logic [2:0] STAT_TIMED_OUT  = 3'd3;
  localparam logic [2:0] STAT_CLEARED    = 3'd4;
  localparam logic [2:0] STAT_SET_NONE   = 3'd5;
  localparam logic [2:0] STAT_WAIT_ERROR = 3'd6;
  localparam logic [2:0] STAT_TO_IGNORED = 3'd7;

  // Bits of the wait mode.
  localparam int MODE_ALL_BIT   = 0;
  localparam int MODE_CLEAR_BIT = 1;

  // Most waiters that one set may release.
  localparam int RESULT_CAP = 8;

  // Classified command as it travels from the front end to the back end.
  typedef struct packed {
    action_e     action;
    logic [2:0]  slot;
    logic [15:0] mask;
    logic [1:0]  mode;
    logic        in_range;
  } cmd_t;

endpackage

// ----- rtl/efg_if.sv -----
// Handshake channels of the event flag group: request items in, result items out.
// Depends on nothing.
interface efg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  thread_slot;
  logic [15:0] mask;
  logic [1:0]  wait_mode;

  modport source (output valid, action, thread_slot, mask, wait_mode, input ready);
  modport sink (input valid, action, thread_slot, mask, wait_mode, output ready);
endinterface

interface efg_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot_out;
  logic [2:0]  status;
  logic [15:0] granted_mask;
  logic [15:0] flags_now;
  logic        last;

  modport source (output valid, slot_out, status, granted_mask, flags_now, last,
                  input ready);
  modport sink (input valid, slot_out, status, granted_mask, flags_now, last,
                output ready);
endinterface

// ----- rtl/efg_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module efg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/efg_front.sv -----
// Front end: accepts request items, classifies them and holds them in a two-entry queue.
// Depends on efg_pkg and the efg_in_if interface.
module efg_front #(
  parameter int WAITER_SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  efg_in_if.sink        req_i,
  output logic          cmd_valid_o,
  output efg_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import efg_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  cmd_t       cls;

  // Classification: decode the action and check the slot against the table size.
  always_comb begin
    cls.action   = action_e'(req_i.action);
    cls.slot     = req_i.thread_slot;
    cls.mask     = req_i.mask;
    cls.mode     = req_i.wait_mode;
    cls.in_range = (32'(req_i.thread_slot) < WAITER_SLOTS);
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= cls;
    end
  end

endmodule

// ----- rtl/efg_back.sv -----
// Back end: keeps the flag word and the waiter table, carries out commands, drives results.
// Depends on efg_pkg, efg_ram and the efg_out_if interface.
module efg_back #(
  parameter int WAITER_SLOTS = 8,
  parameter int FLAG_BITS    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  efg_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  efg_out_if.source     rsp_o
);
  import efg_pkg::*;

  localparam int NS = WAITER_SLOTS;
  localparam int FW = FLAG_BITS;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW = $clog2(NS + 1);
  localparam int LW = $clog2(RESULT_CAP);
  localparam int NW = $clog2(RESULT_CAP + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [FW-1:0] flags_q, flags_d;
  logic [NS-1:0] waiting_q, waiting_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          bval_q, bval_d;
  logic [SW-1:0] bidx_q, bidx_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] emit_q, emit_d;
  logic [FW-1:0] tested_q, tested_d;
  logic [FW-1:0] next_q, next_d;
  logic [FW-1:0] setm_q, setm_d;
  logic [2:0]    lslot_q [RESULT_CAP];
  logic [FW-1:0] lgm_q   [RESULT_CAP];
  logic          lwe;

  logic          ov_q, ov_d;
  logic [2:0]    oslot_q, oslot_d;
  logic [2:0]    ostat_q, ostat_d;
  logic [15:0]   ogm_q, ogm_d;
  logic [15:0]   oflags_q, oflags_d;
  logic          olast_q, olast_d;

  logic          ram_we;
  logic          ram_re;
  logic [FW+1:0] ram_rdata;

  logic [63:0]   m64, s64, b64, fl64, clr64, gw64, gs64;
  logic [FW-1:0] mfw;
  logic [SW-1:0] sidx;
  logic [FW-1:0] clr_flags;
  logic          wmatch;
  logic [FW-1:0] wgm;
  logic [1:0]    smode;
  logic [FW-1:0] smask;
  logic          smatch;
  logic [FW-1:0] sgm;
  logic          release_now;
  logic          out_free;
  logic [LW-1:0] cnt_last;

  // Width conversions between the fixed field widths and the flag and slot widths.
  assign m64       = 64'(cmd_i.mask);
  assign mfw       = m64[FW-1:0];
  assign s64       = 64'(cmd_i.slot);
  assign sidx      = s64[SW-1:0];
  assign b64       = 64'(bidx_q);
  assign fl64      = 64'(flags_q);
  assign clr_flags = flags_q & ~mfw;
  assign clr64     = 64'(clr_flags);

  // Immediate match of a wait against the current flag word.
  always_comb begin
    if (cmd_i.mode[MODE_ALL_BIT]) begin
      wmatch = ((flags_q & mfw) == mfw);
      wgm    = mfw;
    end else begin
      wmatch = ((flags_q & mfw) != '0);
      wgm    = flags_q & mfw;
    end
  end
  assign gw64 = 64'(wgm);

  // Match of the scanned waiter against the flags after the OR.
  assign smode = ram_rdata[FW+1:FW];
  assign smask = ram_rdata[FW-1:0];
  always_comb begin
    if (smode[MODE_ALL_BIT]) begin
      smatch = ((tested_q & smask) == smask);
      sgm    = smask;
    end else begin
      smatch = ((tested_q & smask) != '0);
      sgm    = tested_q & smask;
    end
  end
  assign gs64 = 64'(lgm_q[emit_q]);

  assign release_now = bval_q && waiting_q[bidx_q] && (cnt_q < NW'(RESULT_CAP)) && smatch;
  assign out_free    = !ov_q || rsp_o.ready;
  assign ram_re      = (state_q == ST_SCAN) && (scan_q < CW'(NS));
  assign cnt_last    = LW'(cnt_q - NW'(1));

  efg_ram #(
    .WIDTH (FW + 2),
    .DEPTH (NS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sidx),
    .wdata_i ({cmd_i.mode, mfw}),
    .re_i    (ram_re),
    .raddr_i (scan_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    waiting_d = waiting_q;
    scan_d    = scan_q;
    bval_d    = 1'b0;
    bidx_d    = bidx_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    tested_d  = tested_q;
    next_d    = next_q;
    setm_d    = setm_q;
    lwe       = 1'b0;
    ram_we    = 1'b0;
    cmd_pop_o = 1'b0;
    ov_d      = ov_q && !rsp_o.ready;
    oslot_d   = oslot_q;
    ostat_d   = ostat_q;
    ogm_d     = ogm_q;
    oflags_d  = oflags_q;
    olast_d   = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.action == ACT_SET)) begin
          cmd_pop_o = 1'b1;
          flags_d   = flags_q | mfw;
          tested_d  = flags_q | mfw;
          next_d    = flags_q | mfw;
          setm_d    = mfw;
          scan_d    = '0;
          cnt_d     = '0;
          state_d   = ST_SCAN;
        end else if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          ov_d      = 1'b1;
          oslot_d   = cmd_i.slot;
          ogm_d     = 16'd0;
          oflags_d  = fl64[15:0];
          olast_d   = 1'b1;
          case (cmd_i.action)
            ACT_WAIT: begin
              if (!cmd_i.in_range || waiting_q[sidx]) begin
                ostat_d = STAT_WAIT_ERROR;
              end else if (wmatch) begin
                ostat_d = STAT_GRANTED;
                ogm_d   = gw64[15:0];
              end else begin
                ostat_d         = STAT_BLOCKED;
                ram_we          = 1'b1;
                waiting_d[sidx] = 1'b1;
              end
            end
            ACT_CLEAR: begin
              flags_d  = clr_flags;
              oslot_d  = 3'd0;
              ostat_d  = STAT_CLEARED;
              oflags_d = clr64[15:0];
            end
            default: begin
              if (cmd_i.in_range && waiting_q[sidx]) begin
                ostat_d         = STAT_TIMED_OUT;
                waiting_d[sidx] = 1'b0;
              end else begin
                ostat_d = STAT_TO_IGNORED;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          bval_d = 1'b1;
          bidx_d = scan_q[SW-1:0];
          scan_d = scan_q + CW'(1);
        end
        if (release_now) begin
          waiting_d[bidx_q] = 1'b0;
          lwe               = 1'b1;
          cnt_d             = cnt_q + NW'(1);
          if (smode[MODE_CLEAR_BIT]) begin
            next_d = next_q & ~(smask & setm_q);
          end
        end
        if (!ram_re && !bval_q) begin
          flags_d = next_q;
          emit_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          oflags_d = fl64[15:0];
          if (cnt_q == '0) begin
            oslot_d = 3'd0;
            ostat_d = STAT_SET_NONE;
            ogm_d   = 16'd0;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            oslot_d = lslot_q[emit_q];
            ostat_d = STAT_RELEASED;
            ogm_d   = gs64[15:0];
            olast_d = (emit_q == cnt_last);
            if (emit_q == cnt_last) begin
              state_d = ST_IDLE;
            end else begin
              emit_d = emit_q + LW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      flags_q   <= '0;
      waiting_q <= '0;
      scan_q    <= '0;
      bval_q    <= 1'b0;
      cnt_q     <= '0;
      emit_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      flags_q   <= flags_d;
      waiting_q <= waiting_d;
      scan_q    <= scan_d;
      bval_q    <= bval_d;
      cnt_q     <= cnt_d;
      emit_q    <= emit_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q   <= bidx_d;
    tested_q <= tested_d;
    next_q   <= next_d;
    setm_q   <= setm_d;
    oslot_q  <= oslot_d;
    ostat_q  <= ostat_d;
    ogm_q    <= ogm_d;
    oflags_q <= oflags_d;
    olast_q  <= olast_d;
    if (lwe) begin
      lslot_q[cnt_q[LW-1:0]] <= b64[2:0];
      lgm_q[cnt_q[LW-1:0]]   <= sgm;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.slot_out     = oslot_q;
  assign rsp_o.status       = ostat_q;
  assign rsp_o.granted_mask = ogm_q;
  assign rsp_o.flags_now    = oflags_q;
  assign rsp_o.last         = olast_q;

endmodule

// ----- rtl/event_flag_group_with_waiters_top.sv -----
// Event flag group with waiter slots: a wait, clear or timeout item gives its result from the
// output register once the back end takes it and the output is free. A set item scans the
// waiter table (one slot a cycle through the slot RAM read port), then sends its results, at
// most eight, as the output takes them. The two-entry queue takes items while the back end works.
// Reset (asynchronous, active low) clears the flag word, all waiting bits, the queue and the
// output register at once; the slot RAM is not cleared and needs no clearing pass.
module event_flag_group_with_waiters_top #(
  parameter int WAITER_SLOTS = 8,
  parameter int FLAG_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  efg_in_if.sink    req_i,
  efg_out_if.source rsp_o
);
  import efg_pkg::*;

  // Command handed from the front end to the back end.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // The front end accepts request items, checks the slot against the table size and
  // queues them, so that a new item can be taken while the back end is still busy.
  efg_front #(
    .WAITER_SLOTS (WAITER_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns the flag word and the waiter table. A set first scans every slot,
  // noting the waiters that it releases and the bits their clear modes remove, and then
  // sends the releases in slot order, each carrying the final flag word, or one set-none result.
  efg_back #(
    .WAITER_SLOTS (WAITER_SLOTS),
    .FLAG_BITS    (FLAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

  // The back end only takes a command that the queue really holds.
  a_pop_needs_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  // A command other than a set produces its result in the very next cycle.
  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && (cmd.action != ACT_SET)) |=> rsp_o.valid)
    else $error("single-result command did not reach the output register");

  // A set keeps the back end busy with its scan, so no command follows at once.
  a_set_scans : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && (cmd.action == ACT_SET)) |=> !cmd_pop)
    else $error("command taken during the scan of a set");

endmodule
